FILE: rtl/core/dsd_pkg.sv
`default_nettype none

package dsd_pkg;

  // Nesting limit for structure and header opens.
  localparam int MaxDepth = 8;
  localparam int DepthW   = 4;

  // Number of command entries held between the front and back parts.
  localparam int QueueDepth = 2;

  // Input action codes.
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_START_MODE   = 1'b0;
  localparam logic CFG_NEWLINE_CODE = 1'b1;

  // Control bytes of the escaped format.
  localparam logic [7:0] BYTE_LF    = 8'd10;
  localparam logic [7:0] BYTE_CR    = 8'd13;
  localparam logic [7:0] BYTE_NUM16 = 8'd16;
  localparam logic [7:0] BYTE_NUM17 = 8'd17;
  localparam logic [7:0] BYTE_NUM18 = 8'd18;
  localparam logic [7:0] BYTE_NUM19 = 8'd19;
  localparam logic [7:0] BYTE_OPEN  = 8'd20;
  localparam logic [7:0] BYTE_CLOSE = 8'd21;
  localparam logic [7:0] BYTE_ESC   = 8'd27;
  localparam logic [7:0] CH_CARET   = 8'h5E;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_M       = 8'h6D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_FOUR    = 8'h34;

  // Legacy newline character.
  localparam logic [15:0] LEGACY_NL = 16'hFFFF;

  typedef enum logic [3:0] {
    ST_BIN   = 4'd0,
    ST_TEXT  = 4'd1,
    ST_TYPE  = 4'd2,
    ST_HINT  = 4'd3,
    ST_NUM16 = 4'd4,
    ST_NUM17 = 4'd5,
    ST_NUM18 = 4'd6,
    ST_NUM19 = 4'd7,
    ST_ESC   = 4'd8,
    ST_CSI   = 4'd9,
    ST_CSI1  = 4'd10,
    ST_CSI0  = 4'd11,
    ST_CSI4  = 4'd12
  } parse_st_t;

  typedef enum logic [2:0] {
    KIND_CHAR  = 3'd0,
    KIND_OPEN  = 3'd1,
    KIND_CLOSE = 3'd2,
    KIND_HINT  = 3'd3,
    KIND_END   = 3'd4
  } res_kind_t;

  typedef struct packed {
    logic       action;
    logic [7:0] in_byte;
  } in_word_t;

  typedef struct packed {
    res_kind_t   kind;
    logic [31:0] value;
    logic        legacy;
    logic        overflow;
    logic        last;
  } out_word_t;

  // One result as prepared by the front part.
  typedef struct packed {
    res_kind_t   kind;
    logic [31:0] value;
    logic        overflow;
  } cmd_item_t;

  // One command: either up to three listed results, or an end flush that
  // gives a number of closes followed by the end result.
  typedef struct packed {
    logic              flush;
    logic [DepthW-1:0] nclose;
    logic [1:0]        cnt;
    logic              legacy;
    cmd_item_t [2:0]   items;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/dsd_front.sv
`default_nettype none

module dsd_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire dsd_pkg::in_word_t in_data,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic            cfg_index,
  input  wire logic [31:0]     cfg_data,
  input  wire logic            q_full,
  output logic                 q_push,
  output dsd_pkg::cmd_t        q_data
);
  import dsd_pkg::*;

  typedef struct packed {
    parse_st_t st;
    logic      clr;
    logic      emit;
    logic      dec;
    cmd_item_t item;
  } txt_t;

  // Decode of one byte in plain text state.
  function automatic txt_t text_step(input logic [7:0] c, input logic [DepthW-1:0] dep,
                                     input logic [15:0] nl);
    txt_t r;
    r = '0;
    r.st = ST_TEXT;
    r.item.kind = KIND_CHAR;
    r.item.value = {24'd0, c};
    r.item.overflow = 1'b0;
    case (c)
      BYTE_CR: begin
      end
      BYTE_LF: begin
        r.emit = 1'b1;
        r.item.value = {16'd0, nl};
      end
      BYTE_NUM16: begin
        r.clr = 1'b1;
        r.st = ST_NUM16;
      end
      BYTE_NUM17: begin
        r.clr = 1'b1;
        r.st = ST_NUM17;
      end
      BYTE_NUM18: begin
        r.clr = 1'b1;
        r.st = ST_NUM18;
      end
      BYTE_NUM19: begin
        r.clr = 1'b1;
        r.st = ST_NUM19;
      end
      BYTE_OPEN: begin
        r.st = ST_TYPE;
      end
      BYTE_CLOSE: begin
        if (dep != '0) begin
          r.emit = 1'b1;
          r.dec = 1'b1;
          r.item.kind = KIND_CLOSE;
          r.item.value = '0;
        end
      end
      BYTE_ESC: begin
        r.st = ST_ESC;
      end
      default: begin
        r.emit = 1'b1;
      end
    endcase
    return r;
  endfunction

  logic              start_mode_r, start_mode_nxt;
  logic [15:0]       newline_r, newline_nxt;
  parse_st_t         st_r, st_nxt;
  logic [31:0]       acc_r, acc_nxt;
  logic              leg_r, leg_nxt;
  logic [DepthW-1:0] dep_r, dep_nxt;

  logic        accept;
  logic [7:0]  c;
  logic [15:0] nl;
  logic [5:0]  dig;
  logic        dig_end;
  logic [31:0] acc_shift;
  txt_t        tb;
  logic        use_tb;
  logic [1:0]  tb_slot;
  cmd_t        cmd;
  logic [7:0]  type_byte;
  logic [7:0]  seen;

  // A configuration write is taken only in a cycle in which no input word is accepted.
  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = !accept;
  assign c         = in_data.in_byte;
  assign nl        = leg_r ? LEGACY_NL : newline_r;
  assign tb        = text_step(c, dep_r, nl);

  // Digit value of a number byte; bit 4 or 5 set means the number ends.
  always_comb begin
    if (c inside {[8'h30:8'h39]}) begin
      dig = {2'b00, c[3:0]};
    end else if (c inside {[8'h61:8'h66]}) begin
      dig = 6'(c - 8'h57);
    end else if (c inside {[8'h41:8'h50]}) begin
      dig = 6'(c - 8'h31);
    end else begin
      dig = 6'd32;
    end
  end

  assign dig_end   = dig[5:4] != 2'b00;
  assign acc_shift = {acc_r[27:0], dig[3:0]};
  assign type_byte = (c < 8'd32 || c > 8'd127) ? 8'd0 : c;

  always_comb begin
    case (st_r)
      ST_CSI1: seen = CH_ONE;
      ST_CSI0: seen = CH_ZERO;
      default: seen = CH_FOUR;
    endcase
  end

  // Classification of the accepted word into the next state and a command.
  always_comb begin
    start_mode_nxt = start_mode_r;
    newline_nxt    = newline_r;
    st_nxt         = st_r;
    acc_nxt        = acc_r;
    leg_nxt        = leg_r;
    dep_nxt        = dep_r;
    cmd            = '0;
    cmd.legacy     = leg_r;
    use_tb         = 1'b0;
    tb_slot        = 2'd0;
    for (int k = 0; k < 3; k++) begin
      cmd.items[k].kind = KIND_CHAR;
    end

    if (accept) begin
      if (in_data.action == ACT_END) begin
        cmd.flush  = 1'b1;
        cmd.nclose = dep_r;
        st_nxt     = start_mode_r ? ST_TEXT : ST_BIN;
        acc_nxt    = '0;
        leg_nxt    = 1'b0;
        dep_nxt    = '0;
      end else begin
        case (st_r)
          ST_BIN: begin
            cmd.cnt = 2'd1;
            cmd.items[0].value = (c == BYTE_LF) ? {16'd0, nl} : {24'd0, c};
          end
          ST_TYPE: begin
            if (c == BYTE_NUM18) begin
              st_nxt  = ST_HINT;
              acc_nxt = '0;
            end else begin
              cmd.cnt = 2'd1;
              cmd.items[0].kind  = KIND_OPEN;
              cmd.items[0].value = {24'd0, type_byte};
              if (dep_r < DepthW'(MaxDepth)) begin
                dep_nxt = dep_r + 1'b1;
              end else begin
                cmd.items[0].overflow = 1'b1;
              end
              st_nxt = ST_TEXT;
            end
          end
          ST_HINT, ST_NUM16, ST_NUM17, ST_NUM18, ST_NUM19: begin
            acc_nxt = acc_shift;
            if (dig_end) begin
              st_nxt  = ST_TEXT;
              cmd.cnt = 2'd1;
              case (st_r)
                ST_HINT: begin
                  cmd.items[0].kind  = KIND_HINT;
                  cmd.items[0].value = acc_shift;
                  st_nxt = ST_TYPE;
                end
                ST_NUM18: begin
                  cmd.cnt = 2'd2;
                  cmd.items[0].value = {16'd0, acc_shift[31:16]};
                  cmd.items[1].value = {16'd0, acc_shift[15:0]};
                end
                ST_NUM19: begin
                  cmd.items[0].value = {16'd0, ~acc_shift[15:0]};
                end
                default: begin
                  cmd.items[0].value = {16'd0, acc_shift[15:0]};
                end
              endcase
            end
          end
          ST_ESC: begin
            if (c == CH_CARET || c == CH_BSLASH) begin
              st_nxt = ST_TEXT;
            end else if (c == CH_LBRACK) begin
              st_nxt = ST_CSI;
            end else begin
              use_tb = 1'b1;
            end
          end
          ST_CSI: begin
            if (c == CH_ZERO) begin
              st_nxt = ST_CSI0;
            end else if (c == CH_ONE) begin
              leg_nxt = 1'b1;
              st_nxt  = ST_CSI1;
            end else if (c == CH_FOUR) begin
              leg_nxt = 1'b0;
              st_nxt  = ST_CSI4;
            end else begin
              cmd.items[0].value = {24'd0, CH_LBRACK};
              use_tb  = 1'b1;
              tb_slot = 2'd1;
            end
          end
          ST_CSI1, ST_CSI0, ST_CSI4: begin
            if (c == CH_M) begin
              if (st_r == ST_CSI0) begin
                st_nxt = ST_TEXT;
                if (dep_r != '0) begin
                  dep_nxt = dep_r - 1'b1;
                  cmd.cnt = 2'd1;
                  cmd.items[0].kind  = KIND_CLOSE;
                  cmd.items[0].value = '0;
                end
              end else begin
                st_nxt = ST_TYPE;
              end
            end else begin
              cmd.items[0].value = {24'd0, CH_LBRACK};
              cmd.items[1].value = {24'd0, seen};
              use_tb  = 1'b1;
              tb_slot = 2'd2;
            end
          end
          default: begin
            use_tb = 1'b1;
          end
        endcase

        // Text decode of the byte, placed after any fallback characters.
        if (use_tb) begin
          st_nxt = tb.st;
          if (tb.clr) begin
            acc_nxt = '0;
          end
          if (tb.dec) begin
            dep_nxt = dep_r - 1'b1;
          end
          cmd.cnt = tb.emit ? tb_slot + 2'd1 : tb_slot;
          if (tb.emit) begin
            cmd.items[tb_slot] = tb.item;
          end
        end
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_START_MODE) begin
        start_mode_nxt = cfg_data[0];
        st_nxt  = cfg_data[0] ? ST_TEXT : ST_BIN;
        acc_nxt = '0;
      end else begin
        newline_nxt = cfg_data[15:0];
      end
    end
  end

  assign q_push = accept && (cmd.flush || cmd.cnt != 2'd0);
  assign q_data = cmd;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_mode_r <= 1'b1;
      newline_r    <= 16'd10;
      st_r         <= ST_TEXT;
      acc_r        <= '0;
      leg_r        <= 1'b0;
      dep_r        <= '0;
    end else begin
      start_mode_r <= start_mode_nxt;
      newline_r    <= newline_nxt;
      st_r         <= st_nxt;
      acc_r        <= acc_nxt;
      leg_r        <= leg_nxt;
      dep_r        <= dep_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/dsd_queue.sv
`default_nettype none

module dsd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire dsd_pkg::cmd_t push_data,
  input  wire logic          pop,
  output dsd_pkg::cmd_t      head,
  output logic               empty,
  output logic               full
);
  import dsd_pkg::*;

  cmd_t       mem_r [QueueDepth];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign empty = count_r == 2'd0;
  assign full  = count_r == 2'(QueueDepth);
  assign head  = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // The front part never writes into a full queue.
  assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue written while full");

  // The back part never takes from an empty queue.
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue read while empty");

  // The fill count agrees with the pointers.
  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= 2'(QueueDepth)) &&
    ((count_r == 2'd1) == (wr_ptr_r != rd_ptr_r)))
    else $error("queue count and pointers disagree");

endmodule

`default_nettype wire

FILE: rtl/core/dsd_back.sv
`default_nettype none

module dsd_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire dsd_pkg::cmd_t head,
  input  wire logic          q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output dsd_pkg::out_word_t out_data
);
  import dsd_pkg::*;

  logic [DepthW-1:0] idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_r;
  out_word_t         word;
  cmd_item_t         item;
  logic              load;

  assign item = head.items[idx_r[1:0]];

  // Result word selected by the position within the head command.
  always_comb begin
    word.legacy = head.legacy;
    if (head.flush) begin
      word.value    = '0;
      word.overflow = 1'b0;
      if (idx_r < head.nclose) begin
        word.kind = KIND_CLOSE;
        word.last = 1'b0;
      end else begin
        word.kind = KIND_END;
        word.last = 1'b1;
      end
    end else begin
      word.kind     = item.kind;
      word.value    = item.value;
      word.overflow = item.overflow;
      word.last     = (idx_r[1:0] + 2'd1) == head.cnt;
    end
  end

  // Load the output register when it is free or being taken.
  assign load  = !q_empty && (!out_valid_r || !out_stall);
  assign q_pop = load && word.last;

  always_comb begin
    idx_nxt = idx_r;
    if (q_pop) begin
      idx_nxt = '0;
    end else if (load) begin
      idx_nxt = idx_r + 1'b1;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

FILE: rtl/core/escaped_document_stream_decoder_unit.sv
`default_nettype none

// An accepted byte's result words pass through the command queue and then the output register.
// Throughput: one byte per cycle while each byte gives at most one word and the output is
// not stalled; the output register emits one word per cycle while not stalled, and an end of input
// gives one close per open level plus the end word; a two-entry command queue between the
// decoder and the output side sets how far the input runs ahead.
// Reset (rst_n low, synchronous) restores registers, mode and depth and empties the queue.
module escaped_document_stream_decoder_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire dsd_pkg::in_word_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output dsd_pkg::out_word_t     out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [31:0]       cfg_data
);
  import dsd_pkg::*;

  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  cmd_t q_wdata;
  cmd_t q_head;

  // Byte classification and parser state.
  dsd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  // Command queue between the two sides.
  dsd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // Expansion of commands into result words.
  dsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dsd_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  // Cycles allowed for a byte that gives no word to leave the pipeline.
  localparam int DRAIN_CYCLES = 12;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_START_MODE;
  logic [31:0] cfg_data = '0;

  int gap_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;
  int error_count = 0;
  int bytes_sent = 0;

  // Decoder state as the predictor sees it.
  logic        dec_mode;
  logic [15:0] dec_newline;
  parse_st_t   dec_state;
  logic [31:0] dec_accum;
  logic        dec_legacy;
  logic [3:0]  dec_depth;

  out_word_t expected_words[$];
  out_word_t step_words[$];
  out_word_t want_word;

  escaped_document_stream_decoder_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor of the decoded word stream.
  // ---------------------------------------------------------------------------

  function automatic void reset_decoder();
    dec_mode    = 1'b1;
    dec_newline = 16'd10;
    dec_state   = ST_TEXT;
    dec_accum   = '0;
    dec_legacy  = 1'b0;
    dec_depth   = '0;
  endfunction

  function automatic void push_result(res_kind_t k, logic [31:0] v, logic ovf);
    out_word_t w;
    w.kind     = k;
    w.value    = v;
    w.legacy   = dec_legacy;
    w.overflow = ovf;
    w.last     = 1'b0;
    step_words.push_back(w);
  endfunction

  function automatic logic [31:0] newline_value();
    return dec_legacy ? {16'd0, LEGACY_NL} : {16'd0, dec_newline};
  endfunction

  function automatic void close_level();
    if (dec_depth > 0) begin
      dec_depth = dec_depth - 1'b1;
      push_result(KIND_CLOSE, '0, 1'b0);
    end
  endfunction

  // Plain text handling, also used for the byte that breaks an escape.
  function automatic void text_char(logic [7:0] c);
    dec_state = ST_TEXT;
    case (c)
      BYTE_CR: ;
      BYTE_LF: push_result(KIND_CHAR, newline_value(), 1'b0);
      BYTE_NUM16: begin dec_accum = '0; dec_state = ST_NUM16; end
      BYTE_NUM17: begin dec_accum = '0; dec_state = ST_NUM17; end
      BYTE_NUM18: begin dec_accum = '0; dec_state = ST_NUM18; end
      BYTE_NUM19: begin dec_accum = '0; dec_state = ST_NUM19; end
      BYTE_OPEN: dec_state = ST_TYPE;
      BYTE_CLOSE: close_level();
      BYTE_ESC: dec_state = ST_ESC;
      default: push_result(KIND_CHAR, {24'd0, c}, 1'b0);
    endcase
  endfunction

  // Bits 5:4 flag the end of a number, bits 3:0 carry the nibble.
  function automatic logic [5:0] digit_code(logic [7:0] c);
    if (c >= "0" && c <= "9") return 6'(c - "0");
    if (c >= "a" && c <= "f") return 6'(c - "a" + 10);
    if (c >= "A" && c <= "P") return 6'(c - "A" + 16);
    return 6'd32;
  endfunction

  function automatic void number_char(logic [7:0] c);
    logic [5:0]  d;
    logic [31:0] n;
    d = digit_code(c);
    dec_accum = {dec_accum[27:0], d[3:0]};
    if (d[5:4] == 2'b00) return;
    n = dec_accum;
    case (dec_state)
      ST_HINT: begin
        push_result(KIND_HINT, n, 1'b0);
        dec_state = ST_TYPE;
        return;
      end
      ST_NUM16, ST_NUM17: push_result(KIND_CHAR, {16'd0, n[15:0]}, 1'b0);
      ST_NUM18: begin
        push_result(KIND_CHAR, {16'd0, n[31:16]}, 1'b0);
        push_result(KIND_CHAR, {16'd0, n[15:0]}, 1'b0);
      end
      default: push_result(KIND_CHAR, {16'd0, ~n[15:0]}, 1'b0);
    endcase
    dec_state = ST_TEXT;
  endfunction

  function automatic void decode_byte(logic [7:0] c);
    logic [7:0] t;
    logic [7:0] seen;
    case (dec_state)
      ST_BIN: begin
        push_result(KIND_CHAR, (c == BYTE_LF) ? newline_value() : {24'd0, c}, 1'b0);
      end
      ST_TYPE: begin
        if (c == BYTE_NUM18) begin
          dec_state = ST_HINT;
          dec_accum = '0;
        end else begin
          t = (c < 8'd32 || c > 8'd127) ? 8'd0 : c;
          if (dec_depth < MaxDepth) begin
            dec_depth = dec_depth + 1'b1;
            push_result(KIND_OPEN, {24'd0, t}, 1'b0);
          end else begin
            push_result(KIND_OPEN, {24'd0, t}, 1'b1);
          end
          dec_state = ST_TEXT;
        end
      end
      ST_HINT, ST_NUM16, ST_NUM17, ST_NUM18, ST_NUM19: number_char(c);
      ST_ESC: begin
        if (c == CH_CARET || c == CH_BSLASH) dec_state = ST_TEXT;
        else if (c == CH_LBRACK) dec_state = ST_CSI;
        else text_char(c);
      end
      ST_CSI: begin
        if (c == CH_ZERO) begin
          dec_state = ST_CSI0;
        end else if (c == CH_ONE) begin
          dec_legacy = 1'b1;
          dec_state = ST_CSI1;
        end else if (c == CH_FOUR) begin
          dec_legacy = 1'b0;
          dec_state = ST_CSI4;
        end else begin
          push_result(KIND_CHAR, {24'd0, CH_LBRACK}, 1'b0);
          text_char(c);
        end
      end
      ST_CSI1, ST_CSI0, ST_CSI4: begin
        if (c == CH_M) begin
          if (dec_state == ST_CSI0) begin
            close_level();
            dec_state = ST_TEXT;
          end else begin
            dec_state = ST_TYPE;
          end
        end else begin
          seen = (dec_state == ST_CSI1) ? CH_ONE : ((dec_state == ST_CSI0) ? CH_ZERO : CH_FOUR);
          push_result(KIND_CHAR, {24'd0, CH_LBRACK}, 1'b0);
          push_result(KIND_CHAR, {24'd0, seen}, 1'b0);
          text_char(c);
        end
      end
      default: text_char(c);
    endcase
  endfunction

  // Works out the words one accepted input causes and queues them.
  function automatic void predict_decode(in_word_t w);
    out_word_t tail;
    step_words.delete();
    if (w.action == ACT_END) begin
      while (dec_depth > 0) close_level();
      push_result(KIND_END, '0, 1'b0);
      dec_state  = dec_mode ? ST_TEXT : ST_BIN;
      dec_accum  = '0;
      dec_legacy = 1'b0;
      dec_depth  = '0;
    end else begin
      decode_byte(w.in_byte);
    end
    if (step_words.size() > 0) begin
      tail = step_words[step_words.size() - 1];
      tail.last = 1'b1;
      step_words[step_words.size() - 1] = tail;
    end
    foreach (step_words[i]) expected_words.push_back(step_words[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking, receiver stalls and run limit.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        error_count++;
        $error("unexpected word: kind %0d value %h", out_data.kind, out_data.value);
      end else begin
        want_word = expected_words.pop_front();
        if (out_data.kind !== want_word.kind) begin
          error_count++;
          $error("kind: expected %0d, actual %0d", want_word.kind, out_data.kind);
        end
        if (out_data.value !== want_word.value) begin
          error_count++;
          $error("value: expected %h, actual %h", want_word.value, out_data.value);
        end
        if (out_data.legacy !== want_word.legacy) begin
          error_count++;
          $error("legacy: expected %b, actual %b", want_word.legacy, out_data.legacy);
        end
        if (out_data.overflow !== want_word.overflow) begin
          error_count++;
          $error("overflow: expected %b, actual %b", want_word.overflow, out_data.overflow);
        end
        if (out_data.last !== want_word.last) begin
          error_count++;
          $error("last: expected %b, actual %b", want_word.last, out_data.last);
        end
      end
    end
  end

  // The receiver stalls at random.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sending and configuration.
  // ---------------------------------------------------------------------------

  // Sends one word, with random gaps in front, and predicts it once accepted.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    predict_decode(w);
    bytes_sent++;
  endtask

  task automatic send_byte(input logic [7:0] c);
    in_word_t w;
    w.action  = ACT_BYTE;
    w.in_byte = c;
    send_word(w);
  endtask

  task automatic send_end();
    in_word_t w;
    w.action  = ACT_END;
    w.in_byte = 8'($urandom_range(0, 255));
    send_word(w);
  endtask

  // Holds the input back until every expected word has come out.
  task automatic wait_drained(input int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    wait_drained(DRAIN_CYCLES);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_START_MODE) begin
      dec_mode  = val[0];
      dec_state = val[0] ? ST_TEXT : ST_BIN;
      dec_accum = '0;
    end else begin
      dec_newline = val[15:0];
    end
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Well-formed pieces of a document with random content.
  // ---------------------------------------------------------------------------

  task automatic send_digits(input int count);
    int d;
    repeat (count) begin
      d = $urandom_range(0, 15);
      send_byte((d < 10) ? 8'("0" + d) : 8'("a" + d - 10));
    end
  endtask

  // Final digit of a number, now and then a byte that breaks it.
  task automatic send_number_end();
    if ($urandom_range(0, 99) < 85) send_byte(8'("A" + $urandom_range(0, 15)));
    else send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_open();
    send_byte(BYTE_OPEN);
    if ($urandom_range(0, 99) < 30) begin
      send_byte(BYTE_NUM18);
      send_digits($urandom_range(0, 9));
      send_number_end();
    end
    if ($urandom_range(0, 99) < 80) send_byte(8'($urandom_range(32, 127)));
    else send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_escape();
    int sel;
    sel = $urandom_range(0, 7);
    send_byte(BYTE_ESC);
    case (sel)
      0: send_byte(CH_CARET);
      1: send_byte(CH_BSLASH);
      2, 3: begin
        send_byte(CH_LBRACK);
        send_byte((sel == 2) ? CH_ONE : CH_FOUR);
        send_byte(CH_M);
        send_byte(8'($urandom_range(32, 127)));
      end
      4: begin
        send_byte(CH_LBRACK);
        send_byte(CH_ZERO);
        send_byte(CH_M);
      end
      5: begin
        send_byte(CH_LBRACK);
        send_byte(8'($urandom_range(0, 255)));
      end
      6: begin
        send_byte(CH_LBRACK);
        case ($urandom_range(0, 2))
          0: send_byte(CH_ZERO);
          1: send_byte(CH_ONE);
          default: send_byte(CH_FOUR);
        endcase
        send_byte(8'($urandom_range(0, 255)));
      end
      default: send_byte(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic send_token(input int open_pct);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 28) begin
      send_byte(8'($urandom_range(32, 126)));
    end else if (sel < 36) begin
      send_byte(($urandom_range(0, 1) == 0) ? BYTE_LF : BYTE_CR);
    end else if (sel < 50) begin
      send_byte(8'(BYTE_NUM16 + $urandom_range(0, 3)));
      send_digits($urandom_range(0, 9));
      send_number_end();
    end else if (sel < 50 + open_pct) begin
      send_open();
    end else if (sel < 58 + open_pct) begin
      send_byte(BYTE_CLOSE);
    end else if (sel < 72 + open_pct) begin
      send_escape();
    end else if (sel < 75 + open_pct) begin
      send_end();
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Byte extremes, dropped carriage return, newline and every number form.
  task automatic test_text_and_numbers();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(BYTE_CR);
    send_byte(BYTE_LF);
    send_byte(BYTE_NUM18);
    send_byte("a");
    send_byte("5");
    send_byte("P");
    send_byte(BYTE_NUM16);
    send_byte("3");
    send_byte("B");
    send_byte(BYTE_NUM17);
    send_byte("A");
    send_byte(BYTE_NUM19);
    send_byte("x");
  endtask

  // Opens with and without a size hint, an invalid type, a close with nothing open.
  task automatic test_structures();
    send_byte(BYTE_OPEN);
    send_byte(BYTE_NUM18);
    send_byte("C");
    send_byte(8'h80);
    send_byte(BYTE_OPEN);
    send_byte("T");
    send_byte(BYTE_CLOSE);
    send_byte(BYTE_CLOSE);
    send_byte(BYTE_CLOSE);
  endtask

  // Header sequences, legacy newline, each escape fallback and the end flush.
  task automatic test_escapes();
    send_byte(BYTE_ESC);
    send_byte(CH_CARET);
    send_byte(BYTE_ESC);
    send_byte(CH_LBRACK);
    send_byte(CH_ONE);
    send_byte(CH_M);
    send_byte("H");
    send_byte(BYTE_LF);
    send_byte(BYTE_ESC);
    send_byte(CH_LBRACK);
    send_byte(CH_ZERO);
    send_byte(CH_M);
    send_byte(BYTE_ESC);
    send_byte(CH_LBRACK);
    send_byte(CH_FOUR);
    send_byte("z");
    send_byte(BYTE_ESC);
    send_byte(CH_LBRACK);
    send_byte("q");
    send_byte(BYTE_ESC);
    send_byte("k");
    send_byte(BYTE_OPEN);
    send_byte("S");
    send_end();
  endtask

  task automatic test_binary_mode();
    write_reg(CFG_START_MODE, 32'd0);
    write_reg(CFG_NEWLINE_CODE, 32'd0);
    send_byte(BYTE_LF);
    send_byte(BYTE_ESC);
    send_end();
  endtask

  // Random document stream; the sender drains the block once half way.
  task automatic test_random_stream(input int n_bytes, input int open_pct);
    int first;
    bit paused;
    first = bytes_sent;
    paused = 1'b0;
    while (bytes_sent - first < n_bytes) begin
      send_token(open_pct);
      if (!paused && bytes_sent - first >= n_bytes / 2) begin
        wait_drained(0);
        paused = 1'b1;
      end
    end
  endtask

  // Opens past the depth limit, then a random stream and a flush.
  task automatic test_nesting_limit();
    repeat ($urandom_range(9, 12)) send_open();
    test_random_stream(20, 10);
    send_end();
  endtask

  task automatic test_binary_random();
    write_reg(CFG_START_MODE, 32'd0);
    repeat (20) begin
      case ($urandom_range(0, 9))
        0, 1: send_byte(BYTE_LF);
        2: send_end();
        default: send_byte(8'($urandom_range(0, 255)));
      endcase
    end
    write_reg(CFG_START_MODE, 32'd1);
  endtask

  initial begin
    reset_decoder();
    gap_pct = 7;
    stall_pct = 51;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_text_and_numbers();
    test_structures();
    test_escapes();
    test_binary_mode();

    write_reg(CFG_START_MODE, 32'd1);
    write_reg(CFG_NEWLINE_CODE, 32'($urandom_range(1, 65534)));
    test_random_stream(35, 12);
    test_binary_random();

    gap_pct = 51;
    stall_pct = 7;
    write_reg(CFG_NEWLINE_CODE, 32'hFFFF);
    test_random_stream(35, 12);
    test_nesting_limit();

    gap_pct = 0;
    stall_pct = 0;
    write_reg(CFG_NEWLINE_CODE, 32'd10);
    test_random_stream(25, 12);
    send_end();

    wait_drained(20);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
